/* src/kwm_pkg.sv */
`default_nettype none

package kwm_pkg;

	// default sizes
	localparam int LIST_COUNT_DEF = 8;
	localparam int LIST_DEPTH_DEF = 64;

	// word actions
	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_POP    = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APP_RD,
		ST_APP_WR,
		ST_SCAN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_COMMIT,
		ST_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic app_rd;
		logic app_wr;
		logic scan;
		logic commit;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} sts_t;

endpackage

`default_nettype wire

/* src/kwm_ram.sv */
`default_nettype none

module kwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* src/kwm_ctrl.sv */
`default_nettype none

module kwm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          action,
	output logic               out_valid,
	input  wire logic          out_ready,
	output kwm_pkg::cmd_t      cmd,
	input  wire kwm_pkg::sts_t sts
);

	kwm_pkg::state_t state_q;
	kwm_pkg::state_t state_d;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kwm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (action == kwm_pkg::ACT_POP) ?
						kwm_pkg::ST_SCAN : kwm_pkg::ST_APP_RD;
				end
			end
			kwm_pkg::ST_APP_RD: state_d = kwm_pkg::ST_APP_WR;
			kwm_pkg::ST_APP_WR: state_d = kwm_pkg::ST_FIN;
			kwm_pkg::ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = kwm_pkg::ST_DRAIN1;
				end
			end
			kwm_pkg::ST_DRAIN1: state_d = kwm_pkg::ST_DRAIN2;
			kwm_pkg::ST_DRAIN2: state_d = kwm_pkg::ST_COMMIT;
			kwm_pkg::ST_COMMIT: state_d = kwm_pkg::ST_FIN;
			kwm_pkg::ST_FIN: begin
				if (slot_free) begin
					state_d = kwm_pkg::ST_IDLE;
				end
			end
			default: state_d = kwm_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			kwm_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			kwm_pkg::ST_APP_RD: cmd.app_rd   = 1'b1;
			kwm_pkg::ST_APP_WR: cmd.app_wr   = 1'b1;
			kwm_pkg::ST_SCAN:   cmd.scan     = 1'b1;
			kwm_pkg::ST_COMMIT: cmd.commit   = 1'b1;
			kwm_pkg::ST_FIN:    cmd.load_out = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kwm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* src/kwm_dp.sv */
`default_nettype none

module kwm_dp #(
	parameter int LIST_COUNT = kwm_pkg::LIST_COUNT_DEF,
	parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kwm_pkg::cmd_t      cmd,
	output kwm_pkg::sts_t           sts,
	input  wire logic [2:0]         list_id,
	input  wire logic signed [31:0] value,
	output logic [1:0]              status,
	output logic signed [31:0]      out_value,
	output logic [2:0]              source_list
);

	localparam int LIST_W = $clog2(LIST_COUNT);
	localparam int POS_W  = $clog2(LIST_DEPTH);
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
	localparam int META_W = POS_W + CNT_W;
	localparam int WORDS  = LIST_COUNT * LIST_DEPTH;
	localparam int ADDR_W = $clog2(WORDS);

	// latched word
	logic [2:0]         list_id_q;
	logic signed [31:0] value_q;

	// scan pipeline
	logic [LIST_W-1:0] sc_q;
	logic              vld_s1;
	logic [LIST_W-1:0] idx_s1;
	logic              ne_s2;
	logic [LIST_W-1:0] idx_s2;
	logic [POS_W-1:0]  rp_s2;
	logic [CNT_W-1:0]  fc_s2;

	// running minimum
	logic               found_q;
	logic signed [31:0] best_val_q;
	logic [LIST_W-1:0]  best_idx_q;
	logic [POS_W-1:0]   best_rp_q;
	logic [CNT_W-1:0]   best_fc_q;

	// pending and delivered result
	logic [1:0]         res_status_q;
	logic signed [31:0] res_value_q;
	logic [2:0]         res_src_q;
	logic [1:0]         status_q;
	logic signed [31:0] out_value_q;
	logic [2:0]         source_q;

	// list bookkeeping memory with per-list valid bits
	logic [LIST_COUNT-1:0] meta_vld_q;
	logic                  meta_rv_q;
	logic                  meta_re;
	logic [LIST_W-1:0]     meta_raddr;
	logic [META_W-1:0]     meta_rdata;
	logic                  meta_we;
	logic [LIST_W-1:0]     meta_waddr;
	logic [META_W-1:0]     meta_wdata;
	logic [POS_W-1:0]      rd_rp;
	logic [CNT_W-1:0]      rd_fc;

	// element memory
	logic              elem_we;
	logic [ADDR_W-1:0] elem_waddr;
	logic [ADDR_W-1:0] elem_raddr;
	logic [31:0]       elem_rdata;

	logic [LIST_W-1:0]  app_idx;
	logic               app_full;
	logic [CNT_W:0]     wsum;
	logic [POS_W-1:0]   wpos;
	logic [POS_W-1:0]   pop_rp;
	logic signed [31:0] cand;
	logic               take;

	assign app_idx = LIST_W'(list_id_q);

	// bookkeeping read: append target or scan counter
	assign meta_re    = cmd.app_rd || cmd.scan;
	assign meta_raddr = cmd.scan ? sc_q : app_idx;
	assign rd_rp      = meta_rv_q ? meta_rdata[META_W-1:CNT_W] : '0;
	assign rd_fc      = meta_rv_q ? meta_rdata[CNT_W-1:0] : '0;

	// append decision and ring tail position
	assign app_full = ({29'd0, list_id_q} >= 32'(LIST_COUNT)) ||
		(rd_fc == CNT_W'(LIST_DEPTH));
	assign wsum     = (CNT_W+1)'(rd_rp) + (CNT_W+1)'(rd_fc);
	assign wpos     = (wsum >= (CNT_W+1)'(LIST_DEPTH)) ?
		POS_W'(wsum - (CNT_W+1)'(LIST_DEPTH)) : POS_W'(wsum);

	// head advance of the popped list
	assign pop_rp = (best_rp_q == POS_W'(LIST_DEPTH - 1)) ? '0 : best_rp_q + POS_W'(1);

	// bookkeeping write
	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = app_idx;
		meta_wdata = {rd_rp, rd_fc + CNT_W'(1)};
		if (cmd.app_wr) begin
			meta_we = !app_full;
		end else if (cmd.commit) begin
			meta_we    = found_q;
			meta_waddr = best_idx_q;
			meta_wdata = {pop_rp, best_fc_q - CNT_W'(1)};
		end
	end

	// element write on append, element read in scan stage one
	assign elem_we    = cmd.app_wr && !app_full;
	assign elem_waddr = ADDR_W'(app_idx) * ADDR_W'(LIST_DEPTH) + ADDR_W'(wpos);
	assign elem_raddr = ADDR_W'(idx_s1) * ADDR_W'(LIST_DEPTH) + ADDR_W'(rd_rp);

	kwm_ram #(
		.WIDTH(META_W),
		.DEPTH(LIST_COUNT)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wdata),
		.re   (meta_re),
		.raddr(meta_raddr),
		.rdata(meta_rdata)
	);

	kwm_ram #(
		.WIDTH(32),
		.DEPTH(WORDS)
	) u_elem_ram (
		.clk  (clk),
		.we   (elem_we),
		.waddr(elem_waddr),
		.wdata(value_q),
		.re   (vld_s1),
		.raddr(elem_raddr),
		.rdata(elem_rdata)
	);

	assign sts.scan_last = (sc_q == LIST_W'(LIST_COUNT - 1));

	// stage two compare, lowest index wins on ties
	assign cand = $signed(elem_rdata);
	assign take = ne_s2 && (!found_q || (cand < best_val_q));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_vld_q <= '0;
			meta_rv_q  <= 1'b0;
			sc_q       <= '0;
			vld_s1     <= 1'b0;
			ne_s2      <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			if (meta_we) begin
				meta_vld_q[meta_waddr] <= 1'b1;
			end
			if (meta_re) begin
				meta_rv_q <= meta_vld_q[meta_raddr];
			end
			if (cmd.accept) begin
				sc_q <= '0;
			end else if (cmd.scan) begin
				sc_q <= sc_q + LIST_W'(1);
			end
			vld_s1 <= cmd.scan;
			ne_s2  <= vld_s1 && (rd_fc != '0);
			if (cmd.accept) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			list_id_q <= list_id;
			value_q   <= value;
		end
		idx_s1 <= sc_q;
		idx_s2 <= idx_s1;
		rp_s2  <= rd_rp;
		fc_s2  <= rd_fc;
		if (take) begin
			best_val_q <= cand;
			best_idx_q <= idx_s2;
			best_rp_q  <= rp_s2;
			best_fc_q  <= fc_s2;
		end
		if (cmd.app_wr) begin
			res_status_q <= app_full ? kwm_pkg::STATUS_FULL : kwm_pkg::STATUS_OK;
			res_value_q  <= '0;
			res_src_q    <= '0;
		end else if (cmd.commit) begin
			res_status_q <= found_q ? kwm_pkg::STATUS_OK : kwm_pkg::STATUS_EMPTY;
			res_value_q  <= found_q ? best_val_q : '0;
			res_src_q    <= found_q ? 3'(best_idx_q) : '0;
		end
		if (cmd.load_out) begin
			status_q    <= res_status_q;
			out_value_q <= res_value_q;
			source_q    <= res_src_q;
		end
	end

	assign status      = status_q;
	assign out_value   = out_value_q;
	assign source_list = source_q;

	// a popped list always holds at least one element
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && found_q |-> best_fc_q != '0)
		else $error("pop from an empty list");

	// element memory is never written while the scan reads it
	a_elem_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(elem_we && vld_s1))
		else $error("element write during scan read");

	// a pop with no candidate reports every list empty
	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !found_q |=> res_status_q == kwm_pkg::STATUS_EMPTY)
		else $error("empty pop without empty status");

endmodule

`default_nettype wire

/* src/k_way_sorted_merge_core.sv */
// channel  signals                               direction
// input    in_valid in_ready action list_id value  into block
// output   out_valid out_ready status out_value   out of block
//          source_list
//
// an append word steps through APP_RD and APP_WR before its result; a pop steps through SCAN,
// DRAIN1, DRAIN2 and COMMIT, the scan reading each list's head through the single read port of the
// bookkeeping memory and then of the element memory, one list per cycle.
// reset clears the state machine, the output valid and the per-list valid bits;
// lists read as empty until first written, so no clearing pass is needed.
// a result waiting on out_ready holds the block before its next result is loaded.
`default_nettype none

module k_way_sorted_merge_core #(
	parameter int LIST_COUNT = kwm_pkg::LIST_COUNT_DEF,
	parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               action,
	input  wire logic [2:0]         list_id,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [31:0]      out_value,
	output logic [2:0]              source_list
);

	kwm_pkg::cmd_t cmd;
	kwm_pkg::sts_t sts;

	// sequencing
	kwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// list storage and minimum search
	kwm_dp #(
		.LIST_COUNT(LIST_COUNT),
		.LIST_DEPTH(LIST_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.list_id    (list_id),
		.value      (value),
		.status     (status),
		.out_value  (out_value),
		.source_list(source_list)
	);

endmodule

`default_nettype wire

/* tb/k_way_sorted_merge_core_test.sv */
`timescale 1ns / 1ps

module k_way_sorted_merge_core_test;

	localparam int LISTS = kwm_pkg::LIST_COUNT_DEF;
	localparam int DEPTH = kwm_pkg::LIST_DEPTH_DEF;
	localparam int RANDOM_WORDS = 1830;
	localparam int DIR_ROWS = 21;
	localparam int TOTAL_WORDS = DIR_ROWS + RANDOM_WORDS;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 600;
	localparam int DRAIN_CYCLES = 4 * (LISTS + 5);
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
		logic [2:0]  source;
	} merge_result_t;

	typedef struct packed {
		logic          act;
		logic [2:0]    id;
		logic [31:0]   val;
		logic          typed;
		merge_result_t res;
	} stim_row_t;

	typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIX, SEG_NOISE} segment_t;

	// directed words; typed results only where obvious
	localparam stim_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
		'{kwm_pkg::ACT_POP,    3'd0, 32'd0,         1'b1,
			'{kwm_pkg::STATUS_EMPTY, 32'd0, 3'd0}},
		'{kwm_pkg::ACT_APPEND, 3'd0, 32'h8000_0000, 1'b1,
			'{kwm_pkg::STATUS_OK, 32'd0, 3'd0}},
		'{kwm_pkg::ACT_APPEND, 3'd7, 32'h7fff_ffff, 1'b1,
			'{kwm_pkg::STATUS_OK, 32'd0, 3'd0}},
		'{kwm_pkg::ACT_APPEND, 3'd3, 32'hffff_fffb, 1'b0, '0},
		'{kwm_pkg::ACT_APPEND, 3'd5, 32'hffff_fffb, 1'b0, '0},
		'{kwm_pkg::ACT_APPEND, 3'd6, 32'hffff_ffff, 1'b0, '0},
		'{kwm_pkg::ACT_POP,    3'd0, 32'd0,         1'b1,
			'{kwm_pkg::STATUS_OK, 32'h8000_0000, 3'd0}},
		'{kwm_pkg::ACT_POP,    3'd0, 32'd0,         1'b0, '0},
		'{kwm_pkg::ACT_POP,    3'd0, 32'd0,         1'b0, '0},
		'{kwm_pkg::ACT_POP,    3'd0, 32'd0,         1'b0, '0},
		'{kwm_pkg::ACT_POP,    3'd0, 32'd0,         1'b1,
			'{kwm_pkg::STATUS_OK, 32'h7fff_ffff, 3'd7}},
		'{kwm_pkg::ACT_POP,    3'd0, 32'd0,         1'b1,
			'{kwm_pkg::STATUS_EMPTY, 32'd0, 3'd0}},
		'{kwm_pkg::ACT_APPEND, 3'd2, 32'd10,        1'b0, '0},
		'{kwm_pkg::ACT_APPEND, 3'd2, 32'd3,         1'b0, '0},
		'{kwm_pkg::ACT_APPEND, 3'd1, 32'd5,         1'b0, '0},
		'{kwm_pkg::ACT_APPEND, 3'd4, 32'd0,         1'b0, '0},
		'{kwm_pkg::ACT_POP,    3'd7, 32'h5555_aaaa, 1'b0, '0},
		'{kwm_pkg::ACT_POP,    3'd2, 32'haaaa_5555, 1'b0, '0},
		'{kwm_pkg::ACT_POP,    3'd0, 32'd0,         1'b0, '0},
		'{kwm_pkg::ACT_POP,    3'd0, 32'd0,         1'b0, '0},
		'{kwm_pkg::ACT_POP,    3'd0, 32'd0,         1'b1,
			'{kwm_pkg::STATUS_EMPTY, 32'd0, 3'd0}}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               action;
	logic [2:0]         list_id;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic [2:0]         source_list;

	// typed result travelling with the current word
	logic          row_typed;
	merge_result_t row_result;

	// model of the lists
	logic [31:0] list_words [LISTS][DEPTH];
	int          head_pos [LISTS];
	int          list_fill [LISTS];

	merge_result_t pending_results [$];
	int words_accepted = 0;
	int results_seen = 0;
	int fail_count = 0;
	int cycle_count = 0;

	k_way_sorted_merge_core #(
		.LIST_COUNT(LISTS),
		.LIST_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.list_id(list_id),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_value(out_value),
		.source_list(source_list)
	);

	always #5 clk = ~clk;

	// apply one word to the lists, return what the block should answer
	function automatic merge_result_t merge_step(logic act, logic [2:0] id, logic [31:0] val);
		merge_result_t r;
		int best;
		logic signed [31:0] head;
		logic signed [31:0] best_head;
		r = '0;
		r.status = kwm_pkg::STATUS_OK;
		best = -1;
		best_head = '0;
		if (act == kwm_pkg::ACT_APPEND) begin
			if (int'(id) >= LISTS || list_fill[id] >= DEPTH) begin
				r.status = kwm_pkg::STATUS_FULL;
			end else begin
				list_words[id][(head_pos[id] + list_fill[id]) % DEPTH] = val;
				list_fill[id]++;
			end
		end else begin
			// lowest index wins a tie since only a strictly smaller head replaces it
			for (int i = 0; i < LISTS; i++) begin
				if (list_fill[i] != 0) begin
					head = list_words[i][head_pos[i]];
					if (best < 0 || head < best_head) begin
						best = i;
						best_head = head;
					end
				end
			end
			if (best < 0) begin
				r.status = kwm_pkg::STATUS_EMPTY;
			end else begin
				r.value = best_head;
				r.source = best[2:0];
				head_pos[best] = (head_pos[best] + 1) % DEPTH;
				list_fill[best]--;
			end
		end
		return r;
	endfunction

	// idle percentage of each side for the current phase of the run
	function automatic int idle_pct(bit sender);
		int phase;
		phase = words_accepted * 3 / TOTAL_WORDS;
		if (phase == 0) begin
			return sender ? 14 : 51;
		end else if (phase == 1) begin
			return sender ? 51 : 14;
		end
		return 0;
	endfunction

	task automatic send_word(input logic act, input logic [2:0] id, input logic [31:0] val,
			input logic typed, input merge_result_t typed_res);
		while ($urandom_range(0, 99) < idle_pct(1'b1)) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		list_id <= id;
		value <= val;
		row_typed <= typed;
		row_result <= typed_res;
		do @(posedge clk); while (!in_ready);
	endtask

	// predict on accepted words, check accepted results
	always @(posedge clk) begin : result_check
		merge_result_t exp_r;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				exp_r = merge_step(action, list_id, value);
				if (row_typed) begin
					exp_r = row_result;
				end
				pending_results.push_back(exp_r);
				words_accepted++;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$error("result word with nothing pending: status %0d value %0d source %0d",
						status, out_value, source_list);
					fail_count++;
				end else begin
					exp_r = pending_results.pop_front();
					if (status !== exp_r.status) begin
						$error("status: expected %0d actual %0d", exp_r.status, status);
						fail_count++;
					end
					if (out_value !== exp_r.value) begin
						$error("out_value: expected %0d actual %0d",
							$signed(exp_r.value), out_value);
						fail_count++;
					end
					if (source_list !== exp_r.source) begin
						$error("source_list: expected %0d actual %0d",
							exp_r.source, source_list);
						fail_count++;
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off
	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
			end
		end
	end

	// sender: directed table, then random segments
	initial begin : stimulus
		logic signed [31:0] list_tail [LISTS];
		logic signed [31:0] seed_val;
		segment_t seg_kind;
		int seg_left;
		int seg_list;
		int step;
		int n;
		logic act;
		logic [2:0] id;
		logic [31:0] val;

		arst_n = 1'b0;
		in_valid = 1'b0;
		action = kwm_pkg::ACT_APPEND;
		list_id = '0;
		value = '0;
		row_typed = 1'b0;
		row_result = '0;
		foreach (head_pos[i]) begin
			head_pos[i] = 0;
			list_fill[i] = 0;
			list_tail[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIR_TABLE[r]) begin
			send_word(DIR_TABLE[r].act, DIR_TABLE[r].id, DIR_TABLE[r].val,
				DIR_TABLE[r].typed, DIR_TABLE[r].res);
		end

		// mostly sorted feeds; fill segments push single lists past full and through the wrap
		seg_left = 0;
		seg_kind = SEG_MIX;
		seg_list = 0;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (seg_left == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2: seg_kind = SEG_FILL;
					3, 4, 5: seg_kind = SEG_DRAIN;
					6, 7, 8: seg_kind = SEG_MIX;
					default: seg_kind = SEG_NOISE;
				endcase
				seg_left = $urandom_range(20, 90);
				seg_list = $urandom_range(0, LISTS - 1);
			end
			seg_left--;
			id = 3'($urandom_range(0, 7));
			val = $urandom;
			case (seg_kind)
				SEG_FILL: begin
					act = ($urandom_range(0, 99) < 8) ? kwm_pkg::ACT_POP : kwm_pkg::ACT_APPEND;
					if ($urandom_range(0, 3) != 0) begin
						id = seg_list[2:0];
					end
				end
				SEG_DRAIN: act = ($urandom_range(0, 99) < 85) ?
					kwm_pkg::ACT_POP : kwm_pkg::ACT_APPEND;
				SEG_MIX: act = $urandom_range(0, 1) ? kwm_pkg::ACT_POP : kwm_pkg::ACT_APPEND;
				default: act = 1'($urandom_range(0, 1));
			endcase

			// nondecreasing value per list; restarts when the list runs dry
			if (seg_kind != SEG_NOISE && act == kwm_pkg::ACT_APPEND) begin
				if (list_fill[id] == 0) begin
					seed_val = $urandom;
					list_tail[id] = seed_val >>> $urandom_range(0, 31);
				end else begin
					step = $urandom_range(0, 1) ?
						$urandom_range(0, 3) : $urandom_range(0, 1 << 20);
					if (longint'(list_tail[id]) + step > 64'sh7fff_ffff) begin
						list_tail[id] = 32'sh7fff_ffff;
					end else begin
						list_tail[id] = list_tail[id] + step;
					end
				end
				val = list_tail[id];
			end
			send_word(act, id, val, 1'b0, '0);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
